// File: rtl/core/http_request_header_validator_defines.svh
// ----------------------------------------------------------------------------
// http request header validator assertion macros
// concurrent assertion wrappers, removed for synthesis
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_VALIDATOR_DEFINES_SVH
`define HTTP_REQUEST_HEADER_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define HRHV_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
`define HRHV_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) ante |=> cons) else $error(msg);
`else
`define HRHV_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define HRHV_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg)
`endif

`endif

// File: rtl/core/hrhv_pkg.sv
// ----------------------------------------------------------------------------
// hrhv_pkg
// shared types, text constants and parser step functions
// ----------------------------------------------------------------------------
package hrhv_pkg;

	localparam int          QUEUE_DEPTH     = 4;
	localparam logic [10:0] MAX_BYTES_RESET = 11'd1024;
	localparam logic [11:0] COUNT_MAX       = 12'd4095;
	localparam logic [31:0] BLANK_LINE      = 32'h0d0a0d0a;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;

	localparam logic [7:0] METHOD_TEXT [3] = '{8'h47, 8'h45, 8'h54};
	localparam logic [7:0] LINE_TEXT [13] = '{8'h47, 8'h45, 8'h54, 8'h20, 8'h2f, 8'h20,
		8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e};
	localparam logic [7:0] HOST_TEXT [4] = '{8'h68, 8'h6f, 8'h73, 8'h74};
	localparam logic [7:0] CL_TEXT [14] = '{8'h63, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e,
		8'h74, 8'h2d, 8'h6c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68};
	localparam logic [7:0] TE_TEXT [17] = '{8'h74, 8'h72, 8'h61, 8'h6e, 8'h73, 8'h66,
		8'h65, 8'h72, 8'h2d, 8'h65, 8'h6e, 8'h63, 8'h6f, 8'h64, 8'h69, 8'h6e, 8'h67};
	localparam logic [7:0] ADDR_TEXT [14] = '{8'h31, 8'h39, 8'h32, 8'h2e, 8'h31, 8'h36,
		8'h38, 8'h2e, 8'h34, 8'h2e, 8'h31, 8'h3a, 8'h38, 8'h30};

	typedef enum logic [1:0] {ST_OK, ST_BAD, ST_METHOD, ST_HOST} status_t;
	typedef enum logic [1:0] {PH_REQ, PH_NAME, PH_VALUE, PH_DONE} phase_t;
	typedef enum logic [2:0] {VM_LEAD, VM_MATCH, VM_TRAIL, VM_FAIL, VM_NOTHOST} vmatch_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       is_cr;
		logic       is_lf;
	} item_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] rl_pos;
		logic       f_space;
		logic       f_method;
		logic       f_line;
		logic [4:0] name_pos;
		logic [2:0] cand;
		logic [3:0] value_pos;
		vmatch_t    vm;
		logic       hdr_err;
		logic [1:0] host_cnt;
		logic       host_good;
	} parse_t;

	function automatic parse_t start_line(parse_t s);
		parse_t r;
		r           = s;
		r.name_pos  = '0;
		r.cand      = 3'b111;
		r.value_pos = '0;
		r.vm        = VM_LEAD;
		return r;
	endfunction

	function automatic parse_t parse_reset();
		parse_t r;
		r           = '0;
		r.phase     = PH_REQ;
		r.f_method  = 1'b1;
		r.f_line    = 1'b1;
		r.cand      = 3'b111;
		r.vm        = VM_LEAD;
		return r;
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
	endfunction

	function automatic logic is_name_char(logic [7:0] b);
		return b inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39], 8'h2d};
	endfunction

	function automatic parse_t plain_byte(parse_t s, logic [7:0] b);
		parse_t     r;
		logic [7:0] lb;
		logic       ows;
		logic       is_host;
		logic       forbidden;
		r         = s;
		lb        = to_lower(b);
		ows       = (b == CH_SP) || (b == CH_TAB);
		is_host   = s.cand[0] && (s.name_pos == 5'd4);
		forbidden = (s.cand[1] && (s.name_pos == 5'd14)) || (s.cand[2] && (s.name_pos == 5'd17));
		case (s.phase)
			PH_REQ: begin
				if (!s.f_space) begin
					if (b == CH_SP) begin
						r.f_space = 1'b1;
						if (s.rl_pos != 4'd3)
							r.f_method = 1'b0;
					end else if (s.rl_pos >= 4'd3) begin
						r.f_method = 1'b0;
					end else if (b != METHOD_TEXT[s.rl_pos[1:0]]) begin
						r.f_method = 1'b0;
					end
				end
				if (s.rl_pos < 4'd13) begin
					if (b != LINE_TEXT[s.rl_pos])
						r.f_line = 1'b0;
				end else if (s.rl_pos == 4'd13) begin
					if (b != CH_ZERO && b != CH_ONE)
						r.f_line = 1'b0;
				end else begin
					r.f_line = 1'b0;
				end
				if (s.rl_pos != 4'd15)
					r.rl_pos = s.rl_pos + 4'd1;
			end
			PH_NAME: begin
				if (b == CH_COLON) begin
					if (s.name_pos == 5'd0 || forbidden)
						r.hdr_err = 1'b1;
					if (is_host) begin
						if (s.host_cnt != 2'd3)
							r.host_cnt = s.host_cnt + 2'd1;
						r.vm = VM_LEAD;
					end else begin
						r.vm = VM_NOTHOST;
					end
					r.value_pos = '0;
					r.phase     = PH_VALUE;
				end else begin
					if (!is_name_char(b))
						r.hdr_err = 1'b1;
					if (s.name_pos >= 5'd4)
						r.cand[0] = 1'b0;
					else if (lb != HOST_TEXT[s.name_pos[1:0]])
						r.cand[0] = 1'b0;
					if (s.name_pos >= 5'd14)
						r.cand[1] = 1'b0;
					else if (lb != CL_TEXT[s.name_pos[3:0]])
						r.cand[1] = 1'b0;
					if (s.name_pos >= 5'd17)
						r.cand[2] = 1'b0;
					else if (lb != TE_TEXT[s.name_pos])
						r.cand[2] = 1'b0;
					r.cand = r.cand & s.cand;
					if (s.name_pos != 5'd31)
						r.name_pos = s.name_pos + 5'd1;
				end
			end
			PH_VALUE: begin
				if ((b < CH_SP && b != CH_TAB) || b == CH_DEL)
					r.hdr_err = 1'b1;
				case (s.vm)
					VM_LEAD, VM_MATCH: begin
						if (!(s.vm == VM_LEAD && ows)) begin
							if (ows) begin
								r.vm = VM_TRAIL;
							end else if (s.value_pos < 4'd14 && b == ADDR_TEXT[s.value_pos]) begin
								r.vm        = VM_MATCH;
								r.value_pos = s.value_pos + 4'd1;
							end else begin
								r.vm = VM_FAIL;
							end
						end
					end
					VM_TRAIL: begin
						if (!ows)
							r.vm = VM_FAIL;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic parse_t close_line(parse_t s);
		parse_t r;
		r = s;
		case (s.phase)
			PH_REQ: begin
				if (s.rl_pos != 4'd14)
					r.f_line = 1'b0;
				r.phase = PH_NAME;
				r       = start_line(r);
			end
			PH_NAME: begin
				if (s.name_pos == 5'd0) begin
					r.phase = PH_DONE;
				end else begin
					r.hdr_err = 1'b1;
					r         = start_line(r);
				end
			end
			PH_VALUE: begin
				if (s.vm != VM_NOTHOST)
					r.host_good = (s.vm == VM_MATCH || s.vm == VM_TRAIL) &&
						(s.value_pos == 4'd11 || s.value_pos == 4'd14);
				r.phase = PH_NAME;
				r       = start_line(r);
			end
			default: ;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/http_request_header_validator.sv
// One request byte per cycle while the queue is not full. Bytes are accepted into a
// 4-entry queue (QUEUE_DEPTH) and the parser takes one byte from it each cycle unless
// stalled; a final byte's status is set after the byte leaves the queue, held in a
// one-deep result register that the parser keeps filling past while non-final bytes
// arrive. The parser stalls only on a final byte whose status slot is still occupied
// and not being popped.
// ----------------------------------------------------------------------------
// http_request_header_validator
// streaming request header checker with queue-style ports
// ----------------------------------------------------------------------------
`include "http_request_header_validator_defines.svh"

module http_request_header_validator #(
	parameter int QUEUE_DEPTH = hrhv_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status
);
	import hrhv_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	hrhv_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.data_byte (data_byte),
		.final_byte(final_byte),
		.full      (full),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	hrhv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.status   (status)
	);

	`HRHV_ASSERT(a_pop_needs_item, clk, arst_n, q_pop |-> q_valid, "parser took from an empty queue")
	`HRHV_ASSERT(a_fin_slot_free, clk, arst_n, (q_pop && q_item.fin) |-> (empty || pop), "status slot overwritten")
	`HRHV_ASSERT_NEXT(a_fin_gives_status, clk, arst_n, (q_pop && q_item.fin), !empty, "final item gave no status")

endmodule

// File: rtl/core/hrhv_front.sv
// ----------------------------------------------------------------------------
// hrhv_front
// byte intake: classifies each item and queues it for the parser
// ----------------------------------------------------------------------------
module hrhv_front #(
	parameter int DEPTH = hrhv_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	output logic              full,
	output logic              q_valid,
	output hrhv_pkg::item_t   q_item,
	input  logic              q_pop
);
	import hrhv_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	item_t         item_in;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr_en;
	logic          rd_en;

	always_comb begin
		item_in.data  = data_byte;
		item_in.fin   = final_byte;
		item_in.is_cr = (data_byte == CH_CR);
		item_in.is_lf = (data_byte == CH_LF);
	end

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];
	assign wr_en   = push && !full;
	assign rd_en   = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + CW'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// File: rtl/core/hrhv_back.sv
// ----------------------------------------------------------------------------
// hrhv_back
// parser: line framing, request line and header checks, status register
// ----------------------------------------------------------------------------
module hrhv_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [10:0]     cfg_wdata,
	input  logic            q_valid,
	input  hrhv_pkg::item_t q_item,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output logic [1:0]      status
);
	import hrhv_pkg::*;

	logic [10:0] max_q;
	logic [11:0] count_q;
	logic [23:0] recent_q;
	logic        early_q;
	logic        held_q;
	parse_t      ps_q;
	logic        out_valid_q;
	status_t     status_q;

	logic [31:0] four;
	logic        blank_now;
	logic [11:0] count_n;
	parse_t      ps_cr;
	parse_t      ps_n;
	logic        held_n;
	status_t     status_n;

	assign q_pop     = q_valid && (!q_item.fin || !out_valid_q || pop);
	assign empty     = !out_valid_q;
	assign status    = status_q;
	assign four      = {recent_q, q_item.data};
	assign blank_now = (four == BLANK_LINE);
	assign count_n   = (count_q != COUNT_MAX) ? count_q + 12'd1 : count_q;

	always_comb begin
		ps_cr  = held_q ? plain_byte(ps_q, CH_CR) : ps_q;
		ps_n   = ps_q;
		held_n = 1'b0;
		if (held_q && q_item.is_lf) begin
			ps_n = close_line(ps_q);
		end else if (q_item.is_cr) begin
			ps_n   = ps_cr;
			held_n = 1'b1;
		end else begin
			ps_n = plain_byte(ps_cr, q_item.data);
		end
		if (count_n > {1'b0, max_q} || early_q || !blank_now)
			status_n = ST_BAD;
		else if (!ps_n.f_space)
			status_n = ST_BAD;
		else if (!ps_n.f_method)
			status_n = ST_METHOD;
		else if (!ps_n.f_line || ps_n.hdr_err)
			status_n = ST_BAD;
		else if (ps_n.host_cnt != 2'd1 || !ps_n.host_good)
			status_n = ST_HOST;
		else
			status_n = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_BYTES_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			recent_q <= '0;
			early_q  <= 1'b0;
			held_q   <= 1'b0;
			ps_q     <= parse_reset();
		end else if (q_pop) begin
			if (q_item.fin) begin
				count_q  <= '0;
				recent_q <= '0;
				early_q  <= 1'b0;
				held_q   <= 1'b0;
				ps_q     <= parse_reset();
			end else begin
				count_q  <= count_n;
				recent_q <= four[23:0];
				early_q  <= early_q || blank_now;
				held_q   <= held_n;
				ps_q     <= ps_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (q_pop && q_item.fin) begin
				out_valid_q <= 1'b1;
				status_q    <= status_n;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: tb/tb_http_request_header_validator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_request_header_validator
// streams whole requests byte by byte through the validator, with random
// gaps on the input side and random stalls on the status side, and checks
// every status against a cycle-free model of the parser kept in this file
// ----------------------------------------------------------------------------
module tb_http_request_header_validator;
	import hrhv_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 12;

	typedef struct {
		logic [7:0] b;
		logic       fin;
	} req_byte_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	logic [10:0] cfg_wdata  = '0;
	logic        push       = 1'b0;
	logic [7:0]  data_byte  = '0;
	logic        final_byte = 1'b0;
	logic        pop        = 1'b0;
	logic        full;
	logic        empty;
	logic [1:0]  status;

	req_byte_t   tx_bytes [$];
	status_t     status_due [$];
	logic [7:0]  req_buf [$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          status_count = 0;
	bit          steady = 0;
	int          push_gap = 0;
	int          pop_gap = 0;

	// parser model state
	logic [10:0] max_bytes;
	logic [11:0] byte_cnt;
	logic [23:0] recent;
	logic        early_blank;
	logic        held_cr;
	phase_t      phase;
	logic [3:0]  rl_pos;
	logic        f_space, f_method, f_line;
	logic [4:0]  name_pos;
	logic [2:0]  cand;
	logic [3:0]  value_pos;
	vmatch_t     vm;
	logic        hdr_err;
	logic [1:0]  host_cnt;
	logic        host_ok;

	string       addr_short;
	string       addr_full;
	string       cand_txt [3] = '{"host", "content-length", "transfer-encoding"};
	string       line_txt = "GET / HTTP/1.";

	http_request_header_validator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.empty(empty),
		.pop(pop),
		.status(status)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic void new_line();
		name_pos  = '0;
		cand      = 3'b111;
		value_pos = '0;
		vm        = VM_LEAD;
	endfunction

	function automatic void clear_request();
		byte_cnt    = '0;
		recent      = '0;
		early_blank = 1'b0;
		held_cr     = 1'b0;
		phase       = PH_REQ;
		rl_pos      = '0;
		f_space     = 1'b0;
		f_method    = 1'b1;
		f_line      = 1'b1;
		new_line();
		hdr_err     = 1'b0;
		host_cnt    = '0;
		host_ok     = 1'b0;
	endfunction

	function automatic logic [7:0] lower(logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic void feed(logic [7:0] b);
		logic ows;
		logic is_host, forbid;
		ows = (b == " ") || (b == 8'h09);
		case (phase)
			PH_REQ: begin
				if (!f_space) begin
					if (b == " ") begin
						f_space = 1'b1;
						if (rl_pos != 3)
							f_method = 1'b0;
					end else if (rl_pos >= 3 || b != line_txt[rl_pos]) begin
						f_method = 1'b0;
					end
				end
				if (rl_pos < 13) begin
					if (b != line_txt[rl_pos])
						f_line = 1'b0;
				end else if (rl_pos == 13) begin
					if (b != "0" && b != "1")
						f_line = 1'b0;
				end else begin
					f_line = 1'b0;
				end
				if (rl_pos != 15)
					rl_pos++;
			end
			PH_NAME: begin
				if (b == ":") begin
					is_host = cand[0] && name_pos == 4;
					forbid  = (cand[1] && name_pos == 14) || (cand[2] && name_pos == 17);
					if (name_pos == 0 || forbid)
						hdr_err = 1'b1;
					if (is_host) begin
						if (host_cnt != 3)
							host_cnt++;
						vm = VM_LEAD;
					end else begin
						vm = VM_NOTHOST;
					end
					value_pos = '0;
					phase     = PH_VALUE;
				end else begin
					if (!((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
							(b >= "0" && b <= "9") || b == "-"))
						hdr_err = 1'b1;
					for (int k = 0; k < 3; k++)
						if (cand[k] && (name_pos >= cand_txt[k].len() ||
								lower(b) != cand_txt[k][name_pos]))
							cand[k] = 1'b0;
					if (name_pos != 31)
						name_pos++;
				end
			end
			PH_VALUE: begin
				if ((b < 8'h20 && b != 8'h09) || b == 8'h7f)
					hdr_err = 1'b1;
				if (vm == VM_LEAD) begin
					if (ows)
						return;
					vm = VM_MATCH;
				end
				if (vm == VM_MATCH) begin
					if (ows)
						vm = VM_TRAIL;
					else if (value_pos < 14 && b == addr_full[value_pos])
						value_pos++;
					else
						vm = VM_FAIL;
				end else if (vm == VM_TRAIL && !ows) begin
					vm = VM_FAIL;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void end_line();
		case (phase)
			PH_REQ: begin
				if (rl_pos != 14)
					f_line = 1'b0;
				phase = PH_NAME;
				new_line();
			end
			PH_NAME: begin
				if (name_pos == 0) begin
					phase = PH_DONE;
				end else begin
					hdr_err = 1'b1;
					new_line();
				end
			end
			PH_VALUE: begin
				if (vm != VM_NOTHOST)
					host_ok = (vm == VM_MATCH || vm == VM_TRAIL) &&
						(value_pos == 11 || value_pos == 14);
				phase = PH_NAME;
				new_line();
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_status(logic [7:0] c, logic fin);
		logic [31:0] four;
		logic        blank;
		status_t     st;
		four  = {recent, c};
		blank = (four == 32'h0d0a0d0a);
		if (byte_cnt != 12'd4095)
			byte_cnt++;
		if (held_cr && c == 8'h0a) begin
			held_cr = 1'b0;
			end_line();
		end else begin
			if (held_cr)
				feed(8'h0d);
			if (c == 8'h0d) begin
				held_cr = 1'b1;
			end else begin
				held_cr = 1'b0;
				feed(c);
			end
		end
		recent = four[23:0];
		if (!fin) begin
			if (blank)
				early_blank = 1'b1;
			return;
		end
		if (byte_cnt > max_bytes || early_blank || !blank)
			st = ST_BAD;
		else if (!f_space)
			st = ST_BAD;
		else if (!f_method)
			st = ST_METHOD;
		else if (!f_line || hdr_err)
			st = ST_BAD;
		else if (host_cnt != 1 || !host_ok)
			st = ST_HOST;
		else
			st = ST_OK;
		status_due.push_back(st);
		clear_request();
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			req_buf.push_back(s[i]);
	endfunction

	function automatic void send_buf();
		req_byte_t it;
		foreach (req_buf[i]) begin
			it.b   = req_buf[i];
			it.fin = (i == req_buf.size() - 1);
			tx_bytes.push_back(it);
		end
		req_buf.delete();
	endfunction

	function automatic void send_text(string s);
		put_text(s);
		send_buf();
	endfunction

	function automatic string host_value();
		string v;
		v = "";
		repeat ($urandom_range(0, 2))
			v = {v, ($urandom_range(0, 1) ? " " : "\t")};
		v = {v, ($urandom_range(0, 1) ? addr_full : addr_short)};
		if ($urandom_range(0, 9) == 0)
			v[$urandom_range(0, 9)] = "7";
		repeat ($urandom_range(0, 2))
			v = {v, ($urandom_range(0, 1) ? " " : "\t")};
		return v;
	endfunction

	function automatic void random_request();
		int    nh, host_at, n;
		string s;
		if ($urandom_range(0, 29) == 0) begin
			// raw noise
			n = $urandom_range(1, 8);
			repeat (n)
				req_buf.push_back(8'($urandom_range(0, 255)));
			send_buf();
			return;
		end
		case ($urandom_range(0, 11))
			0: s = "POST / HTTP/1.1";
			1: s = "GET /a HTTP/1.1";
			2: s = "GETX";
			3: s = "GET / HTTP/1.9";
			4: s = "get / HTTP/1.0";
			5, 6, 7: s = "GET / HTTP/1.0";
			default: s = "GET / HTTP/1.1";
		endcase
		put_text({s, "\r\n"});
		nh      = $urandom_range(0, 3);
		host_at = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, nh);
		for (int h = 0; h <= nh; h++) begin
			if (h == host_at)
				put_text({($urandom_range(0, 3) == 0 ? "HOST:" : "Host:"), host_value(), "\r\n"});
			case ($urandom_range(0, 15))
				0: put_text({"Host: ", host_value(), "\r\n"});
				1: put_text("Content-Length: 5\r\n");
				2: put_text("transfer-ENCODING: chunked\r\n");
				3: put_text(": x\r\n");
				4: put_text("Bad Name: x\r\n");
				5: put_text("NoColon\r\n");
				6: put_text("Content-Lengthy: 1\r\n");
				7: put_text("Hos: a\r\n");
				default: put_text("X-Id: ab\tc\r\n");
			endcase
		end
		put_text("\r\n");
		if ($urandom_range(0, 5) == 0)
			req_buf[$urandom_range(0, req_buf.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 19) == 0)
			req_buf.insert($urandom_range(0, req_buf.size() - 1), 8'h0d);
		if ($urandom_range(0, 19) == 0)
			req_buf.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 19) == 0)
			req_buf = req_buf[0:$urandom_range(0, req_buf.size() - 1)];
		send_buf();
	endfunction

	task automatic wait_idle();
		while (tx_bytes.size() != 0 || push || status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_limit(logic [10:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		max_bytes = v;
	endtask

	function automatic void good_request();
		send_text({"GET / HTTP/1.1\r\nHost: ", addr_full, "\r\n\r\n"});
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				void'(tx_bytes.pop_front());
			if (push_gap != 0) begin
				push_gap <= push_gap - 1;
				push     <= 1'b0;
			end else if (!steady && $urandom_range(0, 15) == 0) begin
				push_gap <= $urandom_range(0, 18);
				push     <= 1'b0;
			end else if (tx_bytes.size() > ((push && !full) ? 0 : 0)) begin
				push       <= 1'b1;
				data_byte  <= tx_bytes[0].b;
				final_byte <= tx_bytes[0].fin;
			end else begin
				push <= 1'b0;
			end
			if (pop_gap != 0) begin
				pop_gap <= pop_gap - 1;
				pop     <= 1'b0;
			end else if (!steady && $urandom_range(0, 15) == 0) begin
				pop_gap <= $urandom_range(0, 18);
				pop     <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				predict_status(data_byte, final_byte);
			if (pop && !empty) begin
				if (status_due.size() == 0)
					report_mismatch($sformatf("unexpected status %0d", status));
				else if (status != status_due[0])
					report_mismatch($sformatf("status %0d, expected %0d",
						status, status_due[0]));
				if (status_due.size() != 0)
					void'(status_due.pop_front());
				status_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int v, sent, n0;
		addr_short = $sformatf("%0d.%0d.%0d.%0d", 192, 168, 4, 1);
		addr_full  = {addr_short, ":80"};
		max_bytes  = 11'd1024;
		clear_request();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests at the reset limit
		good_request();
		send_text({"GET / HTTP/1.0\r\nhost:\t", addr_short, " \t\r\n\r\n"});
		send_text({"POST / HTTP/1.1\r\nHost: ", addr_full, "\r\n\r\n"});
		send_text("GETNOSPACE\r\n\r\n");
		send_text("GET / HTTP/1.1\r\nAccept: x\r\n\r\n");
		send_text({"GET / HTTP/1.1\r\nHost: ", addr_full, "\r\nHost: ", addr_full, "\r\n\r\n"});
		send_text("GET / HTTP/1.1\r\nHost: 10.0.0.1\r\n\r\n");
		send_text({"GET / HTTP/1.1\r\nHost: ", addr_full, "\r\nContent-Length: 0\r\n\r\n"});
		send_text({"GET / HTTP/1.1\r\nHost: ", addr_full,
			"\r\nTransfer-Encoding: chunked\r\n\r\n"});
		send_text({"GET / HTTP/1.1\r\n: v\r\nHost: ", addr_full, "\r\n\r\n"});
		send_text({"GET /x HTTP/1.1\r\nHost: ", addr_full, "\r\n\r\n"});
		send_text({"GET / HTTP/1.1\r\nHost: ", addr_full, "\r\n\r\n\r\n\r\n"});
		send_text("\r\n\r");
		send_text({"GET / HTTP/1.1\r\nHo\rst: ", addr_full, "\r\n\r\n"});
		send_text({"GET / HTTP/1.1\r\nHost: ", addr_full, "\r\n\r\nX"});
		send_text({"GET / HTTP/1.1\r\nA: \x7f\x01\r\nHost: ", addr_full, "\r\n\r\n"});
		send_text({"GET / HTTP/1.1\r\nHost: ", addr_full, "\n\r\n\r\n"});
		req_buf.push_back(8'h00);
		req_buf.push_back(8'hff);
		send_buf();
		wait_idle();

		write_limit(11'd0);
		good_request();
		wait_idle();
		write_limit(11'd1);
		good_request();
		send_text("x");
		wait_idle();

		// one request just past the limit, then a short one under it
		write_limit(11'd300);
		put_text("GET / HTTP/1.1\r\n");
		for (int i = 0; i < 7; i++)
			put_text("X-Pad: aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa\r\n");
		put_text({"Host: ", addr_full, "\r\n\r\n"});
		send_buf();
		good_request();
		wait_idle();

		sent = 0;
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: v = 2047;
				1: v = $urandom_range(30, 90);
				default: v = $urandom_range(60, 400);
			endcase
			write_limit(v[10:0]);
			if (p == 7)
				steady = 1;
			while (sent < (p + 1) * 75) begin
				n0 = tx_bytes.size();
				random_request();
				sent = sent + (tx_bytes.size() - n0);
			end
			wait_idle();
		end

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
